// File: design/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg: shared constants for the modular inverse unit
// Operand width and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package mi_pkg;
  localparam int unsigned OPERAND_WIDTH = 31;
  localparam int unsigned SH_W = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [SH_W-1:0]          shift_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_INVERSE   = 2'd1,
    STATUS_ZERO_MODULUS = 2'd2
  } status_e;
endpackage
`default_nettype wire

// File: design/modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// modular_inverse_unit: extended Euclidean modular inverse
// Runs the remainder sequence with a shift-and-subtract divider, one
// shift or one conditional subtract per cycle, and builds the Bezout
// coefficient in the same pass.
// ----------------------------------------------------------------------------
// Sequence: a zero modulus goes from idle straight to the check state;
//   otherwise each Euclid step runs align, subtract and check, with one
//   reduction pass first. Requests: one at a time, taken only in idle.
//   A new request is taken while a result waits.
// Reset: asynchronous, active low; returns to idle with no result pending.
`default_nettype none
module modular_inverse_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mi_pkg::operand_t   value_i,
  input  wire mi_pkg::operand_t   modulus_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mi_pkg::operand_t        inverse_o,
  output logic [1:0]              status_o
);
  import mi_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_SUB   = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ovld_q, ovld_d;
  logic       red_q, red_d, zero_q, zero_d;
  logic       negc_q, negc_d;
  operand_t   m_q, m_d, rc_q, rc_d, cc_q, cc_d;
  operand_t   rem_q, rem_d, dvs_q, dvs_d, cs_q, cs_d, acc_q, acc_d;
  operand_t   inv_q, inv_d;
  logic [1:0] st_q, st_d;
  shift_t     sh_q, sh_d;

  // end-of-step values
  operand_t   n_rp, n_rc, n_cp, n_cc, fin_inv;
  logic       n_negp, n_negc, out_free;

  assign out_free   = !ovld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    if (red_q) begin
      n_rp = m_q;  n_rc = rem_q;
      n_cp = '0;   n_cc = operand_t'(1);
      n_negp = 1'b0; n_negc = 1'b0;
    end else begin
      n_rp = rc_q; n_rc = rem_q;
      n_cp = cc_q; n_cc = acc_q;
      n_negp = negc_q; n_negc = !negc_q;
    end
    if (n_cp == m_q)                fin_inv = '0;
    else if (n_negp && n_cp != '0)  fin_inv = m_q - n_cp;
    else                            fin_inv = n_cp;
  end

  // sequencer and divider datapath
  always_comb begin
    state_d = state_q; ovld_d = ovld_q; red_d = red_q; zero_d = zero_q;
    negc_d = negc_q; m_d = m_q; rc_d = rc_q;
    cc_d = cc_q; rem_d = rem_q; dvs_d = dvs_q; cs_d = cs_q;
    acc_d = acc_q; inv_d = inv_q; st_d = st_q; sh_d = sh_q;
    if (ovld_q && out_ready_i) ovld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          m_d = modulus_i; rem_d = value_i; dvs_d = modulus_i;
          cs_d = '0; acc_d = '0; sh_d = '0; red_d = 1'b1;
          zero_d = (modulus_i == '0);
          state_d = (modulus_i == '0) ? ST_CHECK : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (dvs_q <= (rem_q >> 1)) begin
          dvs_d = dvs_q << 1; cs_d = cs_q << 1; sh_d = sh_q + shift_t'(1);
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        if (dvs_q <= rem_q) begin
          rem_d = rem_q - dvs_q; acc_d = acc_q + cs_q;
        end
        if (sh_q == '0) begin
          state_d = ST_CHECK;
        end else begin
          dvs_d = dvs_q >> 1; cs_d = cs_q >> 1; sh_d = sh_q - shift_t'(1);
        end
      end
      ST_CHECK: begin
        if (zero_q) begin
          if (out_free) begin
            ovld_d = 1'b1; inv_d = '0; st_d = STATUS_ZERO_MODULUS; state_d = ST_IDLE;
          end
        end else if (n_rc == '0) begin
          if (out_free) begin
            ovld_d = 1'b1;
            inv_d  = (n_rp == operand_t'(1)) ? fin_inv : '0;
            st_d   = (n_rp == operand_t'(1)) ? STATUS_OK : STATUS_NO_INVERSE;
            state_d = ST_IDLE;
          end
        end else begin
          rc_d = n_rc; cc_d = n_cc;
          negc_d = n_negc; red_d = 1'b0;
          rem_d = n_rp; dvs_d = n_rc; cs_d = n_cc; acc_d = n_cp; sh_d = '0;
          state_d = ST_ALIGN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
      sh_q    <= '0;
      zero_q  <= 1'b0;
      red_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      sh_q    <= sh_d;
      zero_q  <= zero_d;
      red_q   <= red_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    negc_q <= negc_d; m_q <= m_d; rc_q <= rc_d;
    cc_q <= cc_d; rem_q <= rem_d; dvs_q <= dvs_d; cs_q <= cs_d;
    acc_q <= acc_d; inv_q <= inv_d; st_q <= st_d;
  end

  assign out_valid_o = ovld_q;
  assign inverse_o   = inv_q;
  assign status_o    = st_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && st_q != STATUS_OK |-> inv_q == '0) else $error("error result not zero");
  a_check_sh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> sh_q == '0) else $error("step ended with shift pending");
  a_no_code3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> st_q <= STATUS_ZERO_MODULUS) else $error("bad status code");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("request taken while busy");
endmodule
`default_nettype wire

// File: bench/modular_inverse_unit_tb.sv
// ----------------------------------------------------------------------------
// modular_inverse_unit_tb: self-checking bench for the modular inverse unit
// Random and directed (value, modulus) requests are driven with random gaps,
// the result side stalls at random and once for a long stretch, and every
// result is compared against an extended Euclid computed in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module modular_inverse_unit_tb;
  import mi_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD      = 2000;
  localparam int unsigned RANDOM_COUNT   = 600;

  typedef struct packed {
    operand_t value;
    operand_t modulus;
  } request_t;

  typedef struct packed {
    operand_t inverse;
    status_e  status;
  } answer_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  operand_t value_i;
  operand_t modulus_i;
  logic     out_valid_o;
  logic     out_ready_i;
  operand_t inverse_o;
  logic [1:0] status_o;

  request_t request_q[$];
  answer_t  answer_q[$];
  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  bit          hold_done;
  bit          stimulus_done;
  bit          in_taken;
  bit          out_taken;
  int unsigned status_seen[3];

  modular_inverse_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .modulus_i  (modulus_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .inverse_o  (inverse_o),
    .status_o   (status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Extended Euclid with a signed coefficient
  function automatic answer_t modinv(request_t req);
    answer_t     ans;
    longint      r_old;
    longint      r_now;
    longint      r_tmp;
    longint      t_old;
    longint      t_now;
    longint      t_tmp;
    longint      quot;
    ans.inverse = '0;
    if (req.modulus == 0) begin
      ans.status = STATUS_ZERO_MODULUS;
      return ans;
    end
    r_old = req.modulus;
    r_now = req.value % req.modulus;
    t_old = 0;
    t_now = 1;
    while (r_now != 0) begin
      quot  = r_old / r_now;
      r_tmp = r_old - quot * r_now;
      r_old = r_now;
      r_now = r_tmp;
      t_tmp = t_old - quot * t_now;
      t_old = t_now;
      t_now = t_tmp;
    end
    if (r_old != 1) begin
      ans.status = STATUS_NO_INVERSE;
      return ans;
    end
    t_old = t_old % longint'(req.modulus);
    if (t_old < 0) t_old += req.modulus;
    ans.inverse = operand_t'(t_old);
    ans.status  = STATUS_OK;
    return ans;
  endfunction

  function automatic operand_t rand_operand();
    // Half of the draws are 8 or 16 bits wide to keep the run short, half full width
    case ($urandom_range(0, 9))
      0, 1, 2: return operand_t'($urandom_range(0, 255));
      3, 4:    return operand_t'($urandom_range(0, 65535));
      default: return operand_t'($urandom);
    endcase
  endfunction

  task automatic add_request(operand_t v, operand_t m);
    request_t req;
    req.value   = v;
    req.modulus = m;
    request_q.push_back(req);
  endtask

  // Stimulus: directed corners, then random requests
  initial begin
    operand_t    m;
    operand_t    v;
    int unsigned k;
    stimulus_done = 1'b0;
    add_request('0, '0);
    add_request('1, '0);
    add_request(31'd5, 31'd1);
    add_request('1, 31'd1);
    add_request('0, 31'd7);
    add_request(31'd1, 31'd2);
    add_request(31'd3, 31'd7);
    add_request(31'd10, 31'd7);
    add_request(31'd6, 31'd9);
    add_request(31'd4, 31'd8);
    add_request('1, '1);
    add_request('1 - 1, '1);
    add_request(31'd2, '1);
    add_request('1, 31'd2147483629);
    add_request(31'h55555555, 31'h2AAAAAAB);
    add_request(31'h2AAAAAAA, 31'h55555555);
    add_request(31'd1134903170, 31'd1836311903);
    add_request(31'd1, 31'd1836311903);
    add_request(31'd1836311903, 31'd1134903170);
    for (k = 0; k < RANDOM_COUNT; k++) begin
      m = rand_operand();
      if ($urandom_range(0, 19) == 0) m = '0;
      v = rand_operand();
      // Now and then v is the largest multiple of 3 not above m, a common factor when 3 divides m
      if ($urandom_range(0, 5) == 0 && m > 3) v = (m / 3) * 3;
      add_request(v, m);
    end
    stimulus_done = 1'b1;
  end

  // Handshakes seen at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
    end
  end

  // Request driver
  always @(negedge clk_i or negedge rst_ni) begin
    request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      modulus_i  <= '0;
      send_gap   <= 0;
    end else if (in_valid_i && !in_taken) begin
      // hold until taken
    end else if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (request_q.size() != 0) begin
      req = request_q.pop_front();
      in_valid_i <= 1'b1;
      value_i    <= req.value;
      modulus_i  <= req.modulus;
      answer_q.push_back(modinv(req));
      sent_count++;
      if ($urandom_range(0, 3) == 0) send_gap <= 0;
      else send_gap <= $urandom_range(0, 18);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result side ready: random gaps plus one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && sent_count == 40) begin
      hold_done   <= 1'b1;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (out_taken) begin
      // a result left at the last rising edge; draw the next gap
      if ($urandom_range(0, 3) == 0) begin
        recv_gap <= 0;
      end else begin
        recv_gap    <= $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end
    end else if (recv_gap != 0) begin
      recv_gap    <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result monitor and checker
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result inverse=%0d status=%0d", inverse_o, status_o);
      end else begin
        exp_ans = answer_q.pop_front();
        checked_count++;
        if (exp_ans.status <= STATUS_ZERO_MODULUS) status_seen[exp_ans.status]++;
        if (inverse_o !== exp_ans.inverse || status_o !== exp_ans.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d: expected inverse=%0d status=%0d, got inverse=%0d status=%0d",
                     checked_count, exp_ans.inverse, exp_ans.status, inverse_o, status_o);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Reset, completion wait and final report
  initial begin
    mismatch_count = 0;
    sent_count     = 0;
    checked_count  = 0;
    idle_cycles    = 0;
    status_seen    = '{0, 0, 0};
    rst_ni         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (!(stimulus_done && request_q.size() == 0 && !in_valid_i && answer_q.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", answer_q.size());
      $display("status: fail");
    end else begin
      repeat (300) @(posedge clk_i);
      $display("checked %0d requests: %0d invertible, %0d with common factor, %0d zero modulus",
               checked_count, status_seen[0], status_seen[1], status_seen[2]);
      if (mismatch_count == 0) begin
        $display("status: pass");
      end else begin
        $display("%0d mismatches", mismatch_count);
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
